>>> hdl/dfr_pkg.sv
// shared types and constants for the delimited frame receiver
`default_nettype none

package dfr_pkg;

    // default body store depth, one entry is reserved so MAX_BODY-1 bytes are kept
    localparam int MAX_BODY_DEF = 64;

    // configuration register map
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_START_CHAR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_END_CHAR   = 1'd1;
    localparam logic [7:0] START_CHAR_RST = 8'h02;
    localparam logic [7:0] END_CHAR_RST   = 8'h03;

    // reply texts recognized in a released body
    localparam logic [7:0] ACK_TEXT_0 = 8'h2B;  // '+'
    localparam logic [7:0] ACK_TEXT_1 = 8'h4F;  // 'O'
    localparam logic [7:0] ACK_TEXT_2 = 8'h4B;  // 'K'
    localparam logic [7:0] CLR_TEXT_0 = 8'h2B;  // '+'
    localparam logic [7:0] CLR_TEXT_1 = 8'h43;  // 'C'

    // input beat
    typedef struct packed {
        logic [7:0] rx_byte;
    } t_rx_beat;

    // output beat
    typedef struct packed {
        logic [7:0] body_byte;
        logic [5:0] byte_position;
        logic [5:0] body_length;
        logic       last_of_frame;
        logic       is_ack;
        logic       is_clear;
    } t_frm_beat;

    // controls broadcast to the row of storage cells
    typedef struct packed {
        logic shift;
        logic store;
    } t_cell_ctl;

    // text match result
    typedef struct packed {
        logic ack;
        logic clr;
    } t_match_flags;

endpackage

`default_nettype wire

>>> hdl/dfr_stream_if.sv
// valid/ready stream channel with a typed payload
`default_nettype none

interface dfr_stream_if #(
    parameter type t_payload = logic [7:0]
);
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/dfr_cell.sv
// one body byte cell: loads when addressed, shifts toward the head during readout
`default_nettype none

module dfr_cell #(
    parameter int FILL_W   = 6,
    parameter int CELL_IDX = 0
) (
    input  wire logic              i_clk,
    input  wire dfr_pkg::t_cell_ctl i_ctl,
    input  wire logic [FILL_W-1:0] i_fill,
    input  wire logic [7:0]        i_byte,
    input  wire logic [7:0]        i_next,
    output logic [7:0]             o_byte
);

    logic [7:0] r_byte;
    logic [7:0] n_byte;

    // shift takes the neighbor, otherwise load when the fill pointer hits this cell
    always_comb begin
        n_byte = r_byte;
        if (i_ctl.shift) begin
            n_byte = i_next;
        end else if (i_ctl.store && (i_fill == FILL_W'(CELL_IDX))) begin
            n_byte = i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
    end

    assign o_byte = r_byte;

endmodule

`default_nettype wire

>>> hdl/dfr_match.sv
// running compare of the body text (up to first zero) against "+OK" and "+C"
`default_nettype none

module dfr_match (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_clear,
    input  wire logic  i_store,
    input  wire logic [7:0] i_byte,
    output dfr_pkg::t_match_flags o_flags
);

    // text length saturates at four, which already rules out both texts
    logic       r_zdone;
    logic [2:0] r_zlen;
    logic       r_ack_ok;
    logic       r_clr_ok;
    logic       n_zdone;
    logic [2:0] n_zlen;
    logic       n_ack_ok;
    logic       n_clr_ok;
    logic       ack_hit;
    logic       clr_hit;

    // expected character at the current text position
    always_comb begin
        case (r_zlen)
            3'd0:    ack_hit = (i_byte == dfr_pkg::ACK_TEXT_0);
            3'd1:    ack_hit = (i_byte == dfr_pkg::ACK_TEXT_1);
            3'd2:    ack_hit = (i_byte == dfr_pkg::ACK_TEXT_2);
            default: ack_hit = 1'b1;
        endcase
        case (r_zlen)
            3'd0:    clr_hit = (i_byte == dfr_pkg::CLR_TEXT_0);
            3'd1:    clr_hit = (i_byte == dfr_pkg::CLR_TEXT_1);
            default: clr_hit = 1'b1;
        endcase
    end

    // while no zero byte is seen, text position follows fill position until it saturates
    always_comb begin
        n_zdone  = r_zdone;
        n_zlen   = r_zlen;
        n_ack_ok = r_ack_ok;
        n_clr_ok = r_clr_ok;
        if (i_clear) begin
            n_zdone  = 1'b0;
            n_zlen   = 3'd0;
            n_ack_ok = 1'b1;
            n_clr_ok = 1'b1;
        end else if (i_store && !r_zdone) begin
            if (i_byte == 8'd0) begin
                n_zdone = 1'b1;
            end else begin
                if (r_zlen != 3'd4) begin
                    n_zlen = r_zlen + 3'd1;
                end
                n_ack_ok = r_ack_ok && ack_hit;
                n_clr_ok = r_clr_ok && clr_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zdone  <= 1'b0;
            r_zlen   <= 3'd0;
            r_ack_ok <= 1'b1;
            r_clr_ok <= 1'b1;
        end else begin
            r_zdone  <= n_zdone;
            r_zlen   <= n_zlen;
            r_ack_ok <= n_ack_ok;
            r_clr_ok <= n_clr_ok;
        end
    end

    assign o_flags.ack = r_ack_ok && (r_zlen == 3'd3);
    assign o_flags.clr = r_clr_ok && (r_zlen == 3'd2);

endmodule

`default_nettype wire

>>> hdl/delimited_frame_receiver.sv
// start/end delimited byte deframer built on a row of shifting byte cells
//
//   port        dir   beat          content
//   i_rx        in    t_rx_beat     one received byte
//   o_frm       out   t_frm_beat    one body byte or the terminator of a frame
//   i_cfg_*     in    write only    start_char (index 0), end_char (index 1)
//
// an ordinary byte, a start byte or an ignored byte is taken without holding off i_rx
// an end byte inside a frame releases n+1 output beats, one per cycle at most;
// the readout walks the cell row one shift per body byte and i_rx is held off meanwhile
// o_frm stalls freeze the readout, nothing is lost
// reset is synchronous, active low; the cell row itself is not cleared
`default_nettype none

module delimited_frame_receiver #(
    parameter int MAX_BODY = dfr_pkg::MAX_BODY_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    dfr_stream_if.sink                         i_rx,
    dfr_stream_if.source                       o_frm,
    input  wire logic                          i_cfg_we,
    input  wire logic [dfr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [dfr_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    localparam int NCELL  = MAX_BODY - 1;
    localparam int FILL_W = $clog2(MAX_BODY);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(MAX_BODY - 1);

    logic [7:0]        r_start_char;
    logic [7:0]        r_end_char;
    logic              r_in_frame;
    logic [FILL_W-1:0] r_fill;
    logic              r_drain;
    logic [FILL_W-1:0] r_k;
    logic [FILL_W-1:0] r_n;
    logic              r_ack;
    logic              r_clr;

    logic              in_acc;
    logic              out_acc;
    logic [7:0]        rx_byte;
    logic              is_start;
    logic              is_release;
    logic              do_store;
    logic              at_last;
    dfr_pkg::t_cell_ctl   cell_ctl;
    dfr_pkg::t_match_flags flags;
    logic [7:0]        cell_q [NCELL];

    // handshakes and byte classification
    assign in_acc     = i_rx.valid && i_rx.ready;
    assign out_acc    = o_frm.valid && o_frm.ready;
    assign rx_byte    = i_rx.data.rx_byte;
    assign is_start   = in_acc && (rx_byte == r_start_char);
    assign is_release = in_acc && !is_start && (rx_byte == r_end_char) && r_in_frame;
    assign do_store   = in_acc && !is_start && !is_release && r_in_frame
                        && (r_fill != FILL_MAX);
    assign at_last    = (r_k == r_n);

    assign cell_ctl.store = do_store;
    assign cell_ctl.shift = out_acc && !at_last;

    // row of body cells, head at index 0
    for (genvar g = 0; g < NCELL; g++) begin : g_cell
        logic [7:0] next_byte;
        if (g == NCELL - 1) begin : g_tail
            assign next_byte = 8'd0;
        end else begin : g_mid
            assign next_byte = cell_q[g + 1];
        end
        dfr_cell #(
            .FILL_W  (FILL_W),
            .CELL_IDX(g)
        ) u_cell (
            .i_clk (i_clk),
            .i_ctl (cell_ctl),
            .i_fill(r_fill),
            .i_byte(rx_byte),
            .i_next(next_byte),
            .o_byte(cell_q[g])
        );
    end

    // reply text recognition
    dfr_match u_match (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_clear(is_start),
        .i_store(do_store),
        .i_byte (rx_byte),
        .o_flags(flags)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_char <= dfr_pkg::START_CHAR_RST;
            r_end_char   <= dfr_pkg::END_CHAR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dfr_pkg::REG_START_CHAR: r_start_char <= i_cfg_wdata;
                dfr_pkg::REG_END_CHAR:   r_end_char   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // frame state and readout sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_fill     <= '0;
            r_drain    <= 1'b0;
            r_k        <= '0;
        end else begin
            if (is_start) begin
                r_in_frame <= 1'b1;
                r_fill     <= '0;
            end else if (is_release) begin
                r_in_frame <= 1'b0;
                r_fill     <= '0;
                r_drain    <= 1'b1;
                r_k        <= '0;
            end else if (do_store) begin
                r_fill <= r_fill + FILL_W'(1);
            end
            if (out_acc) begin
                if (at_last) begin
                    r_drain <= 1'b0;
                end else begin
                    r_k <= r_k + FILL_W'(1);
                end
            end
        end
    end

    // frame length and flags captured at release
    always_ff @(posedge i_clk) begin
        if (is_release) begin
            r_n   <= r_fill;
            r_ack <= flags.ack;
            r_clr <= flags.clr;
        end
    end

    // channel outputs
    assign i_rx.ready = !r_drain;

    assign o_frm.valid              = r_drain;
    assign o_frm.data.body_byte     = at_last ? 8'd0 : cell_q[0];
    assign o_frm.data.byte_position = 6'(r_k);
    assign o_frm.data.body_length   = 6'(r_n);
    assign o_frm.data.last_of_frame = at_last;
    assign o_frm.data.is_ack        = r_ack;
    assign o_frm.data.is_clear      = r_clr;

endmodule

`default_nettype wire

>>> verif/testbench.sv
// self-checking testbench for the delimited frame receiver: directed table then random frames
module testbench;
    import dfr_pkg::*;

    localparam int BODY_DEPTH = MAX_BODY_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_BYTES = 30;

    typedef enum logic [1:0] {
        STEP_BYTE,
        STEP_FILL,
        STEP_DELIMS
    } t_step_kind;

    // one row of the directed table; fill rows send a run of plain body bytes
    typedef struct {
        t_step_kind kind;
        logic [7:0] a;
        logic [7:0] b;
        bit         typed;
        t_frm_beat  want;
    } t_step;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    dfr_stream_if #(.t_payload(t_rx_beat))  rx_if ();
    dfr_stream_if #(.t_payload(t_frm_beat)) frm_if ();

    delimited_frame_receiver dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx        (rx_if),
        .o_frm       (frm_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // predictor state and configuration copy
    logic [7:0] start_ch;
    logic [7:0] end_ch;
    bit         open_frame;
    int         body_cnt;
    logic [7:0] body_mem [BODY_DEPTH];

    t_frm_beat frame_beats_due [$];
    t_frm_beat first_release;
    int        released_now;

    t_step script [$];

    // pacing and bookkeeping
    bit rx_lazy;
    bit frm_lazy;
    int stall_left;
    int stall_draw;
    int quiet_cycles;
    int fails;
    int bytes_sent;
    int beats_checked;
    int frames_released;
    int ack_frames;
    int clear_frames;
    int full_frames;
    int delim_writes;

    logic      beat_seen;
    t_frm_beat beat_got;
    t_frm_beat beat_want;

    function automatic t_frm_beat beat(input logic [7:0] b, input logic [5:0] pos,
                                       input logic [5:0] len, input logic last,
                                       input logic ack, input logic clr);
        t_frm_beat r;
        r.body_byte     = b;
        r.byte_position = pos;
        r.body_length   = len;
        r.last_of_frame = last;
        r.is_ack        = ack;
        r.is_clear      = clr;
        return r;
    endfunction

    // length of the body text up to its first zero byte
    function automatic int text_len();
        int z;
        z = 0;
        while (z < body_cnt && body_mem[z] != 8'h00)
            z++;
        return z;
    endfunction

    // advance the predictor by one accepted byte, queue the beats it releases
    function automatic void deframe_byte(input logic [7:0] c);
        int   n;
        int   z;
        logic ack;
        logic clr;
        released_now = 0;
        if (c == start_ch) begin
            body_cnt   = 0;
            open_frame = 1;
        end else if (c == end_ch && open_frame) begin
            n   = body_cnt;
            z   = text_len();
            ack = (z == 3) && body_mem[0] == ACK_TEXT_0 && body_mem[1] == ACK_TEXT_1 &&
                  body_mem[2] == ACK_TEXT_2;
            clr = (z == 2) && body_mem[0] == CLR_TEXT_0 && body_mem[1] == CLR_TEXT_1;
            for (int k = 0; k <= n; k++) begin
                frame_beats_due.push_back(beat((k < n) ? body_mem[k] : 8'h00, 6'(k), 6'(n),
                                               k == n, ack, clr));
                if (k == 0)
                    first_release = frame_beats_due[$];
            end
            released_now = n + 1;
            open_frame   = 0;
            body_cnt     = 0;
        end else if (open_frame && body_cnt < BODY_DEPTH - 1) begin
            body_mem[body_cnt] = c;
            body_cnt++;
        end
    endfunction

    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(0, 255));
        while (b == start_ch || b == end_ch);
        return b;
    endfunction

    task automatic report_miss(input string what, input t_frm_beat want, input t_frm_beat got);
        fails++;
        if (fails <= 10) begin
            $display("%s: want byte %h pos %0d len %0d last %b ack %b clr %b",
                     what, want.body_byte, want.byte_position, want.body_length,
                     want.last_of_frame, want.is_ack, want.is_clear);
            $display("    got byte %h pos %0d len %0d last %b ack %b clr %b",
                     got.body_byte, got.byte_position, got.body_length,
                     got.last_of_frame, got.is_ack, got.is_clear);
        end
    endtask

    // drive one rx beat, after a random gap when rx_lazy is set, and wait for it to be taken
    task automatic send_rx(input logic [7:0] b);
        int gap;
        gap = rx_lazy ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            rx_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        rx_if.valid <= 1'b1;
        rx_if.data  <= t_rx_beat'(b);
        do
            @(posedge i_clk);
        while (rx_if.ready !== 1'b1);
        bytes_sent++;
        deframe_byte(b);
    endtask

    // let every expected beat arrive, then let the block go quiet
    task automatic settle();
        rx_if.valid <= 1'b0;
        while (frame_beats_due.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic load_delims(input logic [7:0] s, input logic [7:0] e);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= REG_START_CHAR;
        i_cfg_wdata <= s;
        @(posedge i_clk);
        start_ch = s;
        i_cfg_idx   <= REG_END_CHAR;
        i_cfg_wdata <= e;
        @(posedge i_clk);
        end_ch = e;
        i_cfg_we <= 1'b0;
        delim_writes += 2;
    endtask

    // a start byte, a body of some shape, usually an end byte
    task automatic send_frame();
        int len;
        len = 0;
        send_rx(start_ch);
        case ($urandom_range(0, 9))
            0: begin
                send_rx(ACK_TEXT_0);
                send_rx(ACK_TEXT_1);
                send_rx(ACK_TEXT_2);
            end
            1: begin
                send_rx(CLR_TEXT_0);
                send_rx(CLR_TEXT_1);
            end
            2: begin
                send_rx(CLR_TEXT_0);
                send_rx(CLR_TEXT_1);
                send_rx(8'h00);
                send_rx(plain_byte());
            end
            3: begin
                send_rx(ACK_TEXT_0);
                send_rx(ACK_TEXT_1);
                send_rx(ACK_TEXT_2);
                send_rx(plain_byte());
            end
            4: begin
                send_rx(ACK_TEXT_0);
                send_rx(ACK_TEXT_1);
            end
            5: begin
                // occasionally run past the body limit
                len = ($urandom_range(0, 2) == 0) ? $urandom_range(58, 72) : $urandom_range(0, 8);
                repeat (len) send_rx(plain_byte());
            end
            default: begin
                len = $urandom_range(0, 8);
                repeat (len) send_rx(plain_byte());
            end
        endcase
        if ($urandom_range(0, 7) != 0)
            send_rx(end_ch);
    endtask

    task automatic row(input t_step_kind kind, input logic [7:0] a, input logic [7:0] b);
        t_step s;
        s.kind  = kind;
        s.a     = a;
        s.b     = b;
        s.typed = 0;
        s.want  = '0;
        script.push_back(s);
    endtask

    task automatic row_want(input logic [7:0] a, input t_frm_beat want);
        t_step s;
        s.kind  = STEP_BYTE;
        s.a     = a;
        s.b     = 8'h00;
        s.typed = 1;
        s.want  = want;
        script.push_back(s);
    endtask

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // output sink with random stalls after each beat when frm_lazy is set
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            frm_if.ready <= 1'b1;
            stall_left   <= 0;
        end else if (frm_if.valid && frm_if.ready) begin
            stall_draw = frm_lazy ? $urandom_range(0, 15) : 0;
            if (stall_draw != 0) begin
                frm_if.ready <= 1'b0;
                stall_left   <= stall_draw;
            end
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            if (stall_left == 1)
                frm_if.ready <= 1'b1;
        end
    end

    // capture accepted output beats at the rising edge, check them on the falling edge
    always @(posedge i_clk) begin
        beat_seen <= i_rst_n && frm_if.valid && frm_if.ready;
        beat_got  <= frm_if.data;
    end

    always @(negedge i_clk) begin
        if (beat_seen === 1'b1) begin
            beats_checked++;
            if (frame_beats_due.size() == 0) begin
                report_miss("unexpected beat", '0, beat_got);
            end else begin
                beat_want = frame_beats_due.pop_front();
                if (beat_got.body_byte !== beat_want.body_byte ||
                    beat_got.byte_position !== beat_want.byte_position ||
                    beat_got.body_length !== beat_want.body_length ||
                    beat_got.last_of_frame !== beat_want.last_of_frame ||
                    beat_got.is_ack !== beat_want.is_ack ||
                    beat_got.is_clear !== beat_want.is_clear)
                    report_miss("beat mismatch", beat_want, beat_got);
                if (beat_want.last_of_frame) begin
                    frames_released++;
                    if (beat_want.is_ack)
                        ack_frames++;
                    if (beat_want.is_clear)
                        clear_frames++;
                    if (beat_want.body_length == 6'(BODY_DEPTH - 1))
                        full_frames++;
                end
            end
        end
    end

    // watchdog on cycles with no traffic at all
    always @(posedge i_clk) begin
        if ((rx_if.valid && rx_if.ready) || (frm_if.valid && frm_if.ready) || i_cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        logic [7:0] phase_start [5];
        logic [7:0] phase_end [5];
        int         quota;

        // known values on every input from time zero
        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_START_CHAR;
        i_cfg_wdata  = '0;
        rx_if.valid  = 1'b0;
        rx_if.data   = '0;
        frm_if.ready = 1'b1;
        quiet_cycles = 0;
        stall_left   = 0;
        fails        = 0;
        start_ch     = START_CHAR_RST;
        end_ch       = END_CHAR_RST;
        open_frame   = 0;
        body_cnt     = 0;
        rx_lazy      = 1;
        frm_lazy     = 1;

        // directed table
        row(STEP_BYTE, 8'h03, 8'h00);                      // end outside a frame
        row(STEP_BYTE, 8'h02, 8'h00);
        row_want(8'h03, beat(8'h00, 6'd0, 6'd0, 1'b1, 1'b0, 1'b0));   // empty frame
        row(STEP_BYTE, 8'h02, 8'h00);
        row(STEP_BYTE, ACK_TEXT_0, 8'h00);
        row(STEP_BYTE, ACK_TEXT_1, 8'h00);
        row(STEP_BYTE, ACK_TEXT_2, 8'h00);
        row_want(8'h03, beat(ACK_TEXT_0, 6'd0, 6'd3, 1'b0, 1'b1, 1'b0));
        // clear text, then a zero byte and trailing data
        row(STEP_BYTE, 8'h02, 8'h00);
        row(STEP_BYTE, CLR_TEXT_0, 8'h00);
        row(STEP_BYTE, CLR_TEXT_1, 8'h00);
        row(STEP_BYTE, 8'h00, 8'h00);
        row(STEP_BYTE, 8'hFF, 8'h00);
        row_want(8'h03, beat(CLR_TEXT_0, 6'd0, 6'd4, 1'b0, 1'b0, 1'b1));
        // start inside a frame throws the body away
        row(STEP_BYTE, 8'h02, 8'h00);
        row(STEP_BYTE, 8'h41, 8'h00);
        row(STEP_BYTE, 8'h02, 8'h00);
        row(STEP_BYTE, 8'h00, 8'h00);
        row_want(8'h03, beat(8'h00, 6'd0, 6'd1, 1'b0, 1'b0, 1'b0));
        // body overflow
        row(STEP_BYTE, 8'h02, 8'h00);
        row(STEP_FILL, 8'd70, 8'h00);
        row(STEP_BYTE, 8'h03, 8'h00);
        // extreme delimiters
        row(STEP_DELIMS, 8'h00, 8'hFF);
        row(STEP_BYTE, 8'hFF, 8'h00);
        row(STEP_BYTE, 8'h00, 8'h00);
        row(STEP_BYTE, 8'h80, 8'h00);
        row_want(8'hFF, beat(8'h80, 6'd0, 6'd1, 1'b0, 1'b0, 1'b0));
        // equal delimiters: start always wins, nothing is released
        row(STEP_DELIMS, 8'h7E, 8'h7E);
        row(STEP_BYTE, 8'h7E, 8'h00);
        row(STEP_BYTE, 8'h41, 8'h00);
        row(STEP_BYTE, 8'h7E, 8'h00);

        phase_start = '{8'h02, 8'hFF, 8'h0A, 8'h55, 8'h00};
        phase_end   = '{8'h03, 8'h00, 8'h0D, 8'h55, 8'h00};
        phase_start[4] = 8'($urandom_range(0, 255));
        phase_end[4]   = 8'($urandom_range(0, 255));

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[i]) begin
            case (script[i].kind)
                STEP_BYTE: begin
                    send_rx(script[i].a);
                    if (script[i].typed && (released_now == 0 || first_release !== script[i].want))
                        report_miss("table row", script[i].want, first_release);
                end
                STEP_FILL: begin
                    repeat (script[i].a) send_rx(plain_byte());
                end
                STEP_DELIMS: begin
                    settle();
                    load_delims(script[i].a, script[i].b);
                end
                default: ;
            endcase
        end

        // random frames under several delimiter settings
        for (int ph = 0; ph < 5; ph++) begin
            settle();
            load_delims(phase_start[ph], phase_end[ph]);
            quota = bytes_sent + PHASE_BYTES;
            while (bytes_sent < quota) begin
                if ($urandom_range(0, 3) == 0)
                    rx_lazy = !rx_lazy;
                if ($urandom_range(0, 3) == 0)
                    frm_lazy = !frm_lazy;
                if ($urandom_range(0, 9) < 8)
                    send_frame();
                else
                    repeat ($urandom_range(1, 4)) send_rx(8'($urandom_range(0, 255)));
            end
        end

        settle();
        fails += frame_beats_due.size();

        $display("sent %0d bytes under %0d delimiter writes; %0d beats checked",
                 bytes_sent, delim_writes, beats_checked);
        $display("frames released %0d: %0d ack, %0d clear, %0d at the body limit",
                 frames_released, ack_frames, clear_frames, full_frames);
        if (fails == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> delimited_frame_receiver.f
hdl/dfr_pkg.sv
hdl/dfr_stream_if.sv
hdl/dfr_cell.sv
hdl/dfr_match.sv
hdl/delimited_frame_receiver.sv
verif/testbench.sv
